### rtl/mlq_pkg.sv
// Shared types and codes for the multilevel queue scheduler.
// No dependencies; the scheduler and its checker import this package.
`timescale 1ns / 1ps

package mlq_pkg;

   // Fixed port widths
   localparam int REQ_W    = 2;
   localparam int PORT_ID_W = 8;
   localparam int PRI_W    = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_ENQ = 2'd0;
   localparam logic [REQ_W-1:0] REQ_REM = 2'd1;
   localparam logic [REQ_W-1:0] REQ_SEL = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SEARCH,
      S_SHIFT,
      S_SEL_WB
   } state_type;

endpackage

### rtl/mlq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module mlq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 80
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/multilevel_queue_scheduler.sv
// Multilevel queue scheduler: per-level round-robin FIFOs kept in one shared RAM.
// Depends on mlq_pkg and mlq_ram.
`timescale 1ns / 1ps

// Holds NUM_LEVELS ready queues (level 1 lowest .. NUM_LEVELS highest), each a
// circular FIFO of LEVEL_DEPTH process IDs, all in one RAM. A transaction is
// taken when start is high and busy is low; its single result appears on the
// rsp_ ports for exactly one cycle with rsp_valid high, and busy drops in that
// same cycle so the next transaction can be taken right away. Enqueue, every
// rejected request, a remove on an empty level and a select with all levels
// empty finish in the decode state; a select that finds a process first reads
// the RAM, then copies the head to the tail; any other remove walks the
// addressed level's queue one RAM entry per cycle: first a search for the ID,
// then a one-slot shift of the entries behind it. The RAM port (one read and
// one write per cycle) sets that walk rate. Queue contents need no clearing
// after reset; only the per-level head and count registers, the total and the
// control state reset.

module multilevel_queue_scheduler
   import mlq_pkg::*;
#(
   parameter int NUM_LEVELS  = 5,
   parameter int LEVEL_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [REQ_W-1:0]     req_type,
   input  logic [PORT_ID_W-1:0] req_proc_id,
   input  logic [PRI_W-1:0]     req_priority_req,
   input  logic                 req_proc_ready,
   input  logic                 req_ignore_state,
   output logic                 rsp_valid,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_sel_valid,
   output logic [PORT_ID_W-1:0] rsp_sel_id,
   output logic [COUNT_W-1:0]   rsp_total_count
);

   localparam int LvlW  = $clog2(NUM_LEVELS);
   localparam int HeadW = $clog2(LEVEL_DEPTH);
   localparam int CntW  = $clog2(LEVEL_DEPTH + 1);
   localparam int SumW  = $clog2(2 * LEVEL_DEPTH);
   localparam int Depth = NUM_LEVELS * LEVEL_DEPTH;
   localparam int AddrW = $clog2(Depth);
   localparam int TotW  = $clog2(Depth + 1);

   // RAM address of position pos in level lvl
   function automatic logic [AddrW-1:0] slot(input logic [LvlW-1:0] lvl,
                                             input logic [HeadW-1:0] pos);
      return AddrW'(lvl) * AddrW'(LEVEL_DEPTH) + AddrW'(pos);
   endfunction

   // head + offset is always below 2*LEVEL_DEPTH: one compare and subtract
   function automatic logic [HeadW-1:0] wrap(input logic [SumW-1:0] s);
      return (s >= SumW'(LEVEL_DEPTH)) ? HeadW'(s - SumW'(LEVEL_DEPTH)) : HeadW'(s);
   endfunction

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   state_type state_ff, state_in;

   logic [HeadW-1:0] head_ff  [NUM_LEVELS];
   logic [CntW-1:0]  count_ff [NUM_LEVELS];
   logic [TotW-1:0]  total_ff, total_in;

   // latched transaction
   logic [REQ_W-1:0]   op_ff;
   logic [ID_BITS-1:0] id_ff;
   logic [PRI_W-1:0]   pri_ff;
   logic               ready_ff;
   logic               ign_ff;

   // working copies for the addressed level
   logic [LvlW-1:0]  cur_lvl_ff, cur_lvl_in;
   logic [HeadW-1:0] h_ff, h_in;
   logic [CntW-1:0]  n_ff, n_in;
   logic [CntW-1:0]  k_ff, k_in;

   // result registers
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_sel_valid_ff;
   logic [ID_BITS-1:0]  rsp_sel_id_ff;

   // RAM
   logic               ram_we;
   logic [AddrW-1:0]   ram_wr_addr;
   logic [ID_BITS-1:0] ram_wr_data;
   logic [AddrW-1:0]   ram_rd_addr;
   logic [ID_BITS-1:0] ram_rd_data;

   mlq_ram #(
      .WIDTH(ID_BITS),
      .DEPTH(Depth)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // ---------------------------------------------------------------------
   // Conditions
   // ---------------------------------------------------------------------
   logic            pri_ok;
   logic [LvlW-1:0] lvl_pri;
   logic            top_found;
   logic [LvlW-1:0] top_lvl;
   logic [LvlW-1:0] cur_lvl;
   logic [HeadW-1:0] head_cur;
   logic [CntW-1:0]  cnt_cur;
   logic            enq_err, rem_err, lvl_full, lvl_empty;
   logic            id_match, k_last;
   logic [CntW-1:0] k_next;

   always_comb begin
      pri_ok  = (pri_ff != '0) && (32'(pri_ff) <= NUM_LEVELS);
      lvl_pri = LvlW'(pri_ff - PRI_W'(1));

      // highest non-empty level wins
      top_found = 1'b0;
      top_lvl   = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (count_ff[i] != '0) begin
            top_found = 1'b1;
            top_lvl   = LvlW'(i);
         end
      end

      cur_lvl  = (op_ff == REQ_SEL) ? top_lvl : lvl_pri;
      head_cur = head_ff[cur_lvl];
      cnt_cur  = count_ff[cur_lvl];

      enq_err   = (!ready_ff && !ign_ff) || !pri_ok;
      rem_err   = (ready_ff && !ign_ff) || !pri_ok;
      lvl_full  = cnt_cur >= CntW'(LEVEL_DEPTH);
      lvl_empty = cnt_cur == '0;

      id_match = ram_rd_data == id_ff;
      k_next   = k_ff + CntW'(1);
      k_last   = k_next == n_ff;
   end

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (op_ff)
               REQ_REM: begin
                  state_in = (!rem_err && !lvl_empty) ? S_SEARCH : S_IDLE;
               end
               REQ_SEL: begin
                  state_in = top_found ? S_SEL_WB : S_IDLE;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SEARCH: begin
            if (k_last) begin
               state_in = S_IDLE;
            end else if (id_match) begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (k_last) begin
               state_in = S_IDLE;
            end
         end
         S_SEL_WB: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath and outputs
   // ---------------------------------------------------------------------
   logic                finish;
   logic [STATUS_W-1:0] fin_status;
   logic                fin_sel_valid;
   logic [ID_BITS-1:0]  fin_sel_id;
   logic                cnt_we;
   logic [LvlW-1:0]     cnt_idx;
   logic [CntW-1:0]     cnt_wdata;
   logic                head_we;
   logic [HeadW-1:0]    head_wdata;

   always_comb begin
      finish        = 1'b0;
      fin_status    = ST_INVALID;
      fin_sel_valid = 1'b0;
      fin_sel_id    = '0;
      cnt_we        = 1'b0;
      cnt_idx       = cur_lvl_ff;
      cnt_wdata     = n_ff - CntW'(1);
      head_we       = 1'b0;
      head_wdata    = wrap(SumW'(h_ff) + SumW'(1));
      total_in      = total_ff;
      ram_we        = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = ram_rd_data;
      ram_rd_addr   = '0;
      cur_lvl_in    = cur_lvl_ff;
      h_in          = h_ff;
      n_in          = n_ff;
      k_in          = k_ff;

      case (state_ff)
         S_DECODE: begin
            cur_lvl_in = cur_lvl;
            h_in       = head_cur;
            n_in       = cnt_cur;
            k_in       = '0;
            ram_rd_addr = slot(cur_lvl, head_cur);
            case (op_ff)
               REQ_ENQ: begin
                  finish = 1'b1;
                  if (enq_err) begin
                     fin_status = ST_INVALID;
                  end else if (lvl_full) begin
                     fin_status = ST_FULL;
                  end else begin
                     fin_status  = ST_OK;
                     ram_we      = 1'b1;
                     ram_wr_addr = slot(cur_lvl, wrap(SumW'(head_cur) + SumW'(cnt_cur)));
                     ram_wr_data = id_ff;
                     cnt_we      = 1'b1;
                     cnt_idx     = cur_lvl;
                     cnt_wdata   = cnt_cur + CntW'(1);
                     total_in    = total_ff + TotW'(1);
                  end
               end
               REQ_REM: begin
                  if (rem_err) begin
                     finish     = 1'b1;
                     fin_status = ST_INVALID;
                  end else if (lvl_empty) begin
                     finish     = 1'b1;
                     fin_status = ST_NOT_FOUND;
                  end
               end
               REQ_SEL: begin
                  if (!top_found) begin
                     finish     = 1'b1;
                     fin_status = ST_NOT_FOUND;
                  end
               end
               default: begin
                  finish     = 1'b1;
                  fin_status = ST_INVALID;
               end
            endcase
         end
         S_SEARCH: begin
            // read data holds position k; fetch k+1 in case the walk goes on
            ram_rd_addr = slot(cur_lvl_ff, wrap(SumW'(h_ff) + SumW'(k_next)));
            k_in        = k_next;
            if (id_match && k_last) begin
               finish     = 1'b1;
               fin_status = ST_OK;
               cnt_we     = 1'b1;
               total_in   = total_ff - TotW'(1);
            end else if (k_last) begin
               finish     = 1'b1;
               fin_status = ST_NOT_FOUND;
            end
         end
         S_SHIFT: begin
            // move position k down to k-1
            ram_we      = 1'b1;
            ram_wr_addr = slot(cur_lvl_ff, wrap(SumW'(h_ff) + SumW'(k_ff) - SumW'(1)));
            ram_rd_addr = slot(cur_lvl_ff, wrap(SumW'(h_ff) + SumW'(k_next)));
            k_in        = k_next;
            if (k_last) begin
               finish     = 1'b1;
               fin_status = ST_OK;
               cnt_we     = 1'b1;
               total_in   = total_ff - TotW'(1);
            end
         end
         S_SEL_WB: begin
            // old head goes to the tail, head advances
            ram_we        = 1'b1;
            ram_wr_addr   = slot(cur_lvl_ff, wrap(SumW'(h_ff) + SumW'(n_ff)));
            head_we       = 1'b1;
            finish        = 1'b1;
            fin_status    = ST_OK;
            fin_sel_valid = 1'b1;
            fin_sel_id    = ram_rd_data;
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= finish;
         if (cnt_we) begin
            count_ff[cnt_idx] <= cnt_wdata;
         end
         if (head_we) begin
            head_ff[cur_lvl_ff] <= head_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         op_ff    <= req_type;
         id_ff    <= ID_BITS'(req_proc_id);
         pri_ff   <= req_priority_req;
         ready_ff <= req_proc_ready;
         ign_ff   <= req_ignore_state;
      end
      cur_lvl_ff <= cur_lvl_in;
      h_ff       <= h_in;
      n_ff       <= n_in;
      k_ff       <= k_in;
      if (finish) begin
         rsp_status_ff    <= fin_status;
         rsp_sel_valid_ff <= fin_sel_valid;
         rsp_sel_id_ff    <= fin_sel_id;
      end
   end

   assign busy            = state_ff != S_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_sel_valid   = rsp_sel_valid_ff;
   assign rsp_sel_id      = PORT_ID_W'(rsp_sel_id_ff);
   assign rsp_total_count = COUNT_W'(total_ff);

endmodule

### rtl/mlq_checker.sv
// Port-level checks for the multilevel queue scheduler, bound to its top level.
// Depends on mlq_pkg.
`timescale 1ns / 1ps

module mlq_checker
   import mlq_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic [STATUS_W-1:0]  rsp_status,
   input logic                 rsp_sel_valid,
   input logic [PORT_ID_W-1:0] rsp_sel_id
);

   // an accepted transaction makes the block busy in the following cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accepted transaction");

   // results are single-cycle strobes, never back to back
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // the block is ready again when the result shows
   a_idle_at_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy while result strobe is high");

   // a selected process always comes with success
   a_sel_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sel_valid |-> rsp_status == ST_OK)
      else $error("selected process reported without success status");

   // no selection means a zero ID
   a_sel_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sel_valid |-> rsp_sel_id == '0)
      else $error("nonzero ID without a selection");

endmodule

bind multilevel_queue_scheduler mlq_checker u_mlq_checker (.*);
